/* rtl/csvfs_pkg.sv */
// csvfs_pkg: shared types and constants for the CSV field splitter.
// No dependencies; used by every module under rtl.
package csvfs_pkg;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [6:0] FIELD_LIMIT = 7'd64;
	localparam logic [5:0] SPACE_CAP   = 6'd63;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CFG_MAX_FIELDS  = 2'd0;
	localparam logic [1:0] CFG_TRIM_ENABLE = 2'd1;
	localparam logic [1:0] CFG_QUOTE_CHAR  = 2'd2;

	localparam logic [6:0] RST_MAX_FIELDS  = 7'd16;
	localparam logic       RST_TRIM_ENABLE = 1'b1;
	localparam logic [7:0] RST_QUOTE_CHAR  = 8'd34;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		logic       is_quote;
		logic       is_comma;
		logic       is_space;
	} item_t;

	typedef struct packed {
		logic [6:0] field_cap;
		logic       trim;
	} cfg_t;

	typedef enum logic [3:0] {
		ACT_IGNORE,
		ACT_DROP,
		ACT_HOLD,
		ACT_OPEN,
		ACT_PEND,
		ACT_EMIT,
		ACT_LITQ,
		ACT_END,
		ACT_CAPEOL
	} action_t;

endpackage

/* rtl/csvfs_front.sv */
// csvfs_front: configuration registers and character classifier.
// Depends on csvfs_pkg.
module csvfs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic [7:0]          in_char,
	input  logic                end_of_line,
	output csvfs_pkg::cfg_t     cfg,
	output csvfs_pkg::item_t    item
);

	logic [6:0] max_fields_q;
	logic       trim_q;
	logic [7:0] quote_q;
	logic [6:0] cap_min1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= csvfs_pkg::RST_MAX_FIELDS;
			trim_q       <= csvfs_pkg::RST_TRIM_ENABLE;
			quote_q      <= csvfs_pkg::RST_QUOTE_CHAR;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				csvfs_pkg::CFG_MAX_FIELDS:  max_fields_q <= cfg_data[6:0];
				csvfs_pkg::CFG_TRIM_ENABLE: trim_q       <= cfg_data[0];
				csvfs_pkg::CFG_QUOTE_CHAR:  quote_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cap_min1 = (max_fields_q == 7'd0) ? 7'd1 : max_fields_q;
		cfg.field_cap = (cap_min1 > csvfs_pkg::FIELD_LIMIT) ? csvfs_pkg::FIELD_LIMIT
			: cap_min1;
		cfg.trim = trim_q;
	end

	always_comb begin
		item.ch       = in_char;
		item.eol      = end_of_line;
		item.is_quote = (quote_q != 8'd0) && (in_char == quote_q);
		item.is_comma = (in_char == csvfs_pkg::CHAR_COMMA);
		item.is_space = (in_char == csvfs_pkg::CHAR_SPACE);
	end

endmodule

/* rtl/csvfs_queue.sv */
// csvfs_queue: short register queue of classified characters between front and back.
// Depends on csvfs_pkg.
module csvfs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csvfs_pkg::item_t  push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output csvfs_pkg::item_t  head_item
);

	csvfs_pkg::item_t                  entry_q [csvfs_pkg::QUEUE_DEPTH];
	logic [csvfs_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [csvfs_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [csvfs_pkg::QCNT_W-1:0]      count_q;

	localparam logic [csvfs_pkg::QPTR_W-1:0] PTR_LAST =
		csvfs_pkg::QPTR_W'(csvfs_pkg::QUEUE_DEPTH - 1);
	localparam logic [csvfs_pkg::QCNT_W-1:0] CNT_FULL =
		csvfs_pkg::QCNT_W'(csvfs_pkg::QUEUE_DEPTH);

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/csvfs_back.sv */
// csvfs_back: field/quote state, step decoder and output register.
// Depends on csvfs_pkg.
module csvfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  csvfs_pkg::cfg_t   cfg,
	input  logic              head_valid,
	input  csvfs_pkg::item_t  head_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              lead_quote,
	output logic [5:0]        lead_spaces,
	output logic              char_valid,
	output logic [7:0]        out_char,
	output logic              field_end,
	output logic [5:0]        field_index,
	output logic              line_end,
	output logic [6:0]        field_count,
	output logic              space_overflow
);

	typedef struct packed {
		logic       lead_quote;
		logic [5:0] lead_spaces;
		logic       char_valid;
		logic [7:0] out_char;
		logic       field_end;
		logic [5:0] field_index;
		logic       line_end;
		logic [6:0] field_count;
		logic       space_overflow;
	} result_t;

	logic       inside_quote_q;
	logic       has_content_q;
	logic       close_pending_q;
	logic       skip_quote_q;
	logic [5:0] held_spaces_q;
	logic       held_ovf_q;
	logic [6:0] fields_done_q;

	logic       out_valid_q;
	result_t    out_q;

	csvfs_pkg::action_t act;
	logic       act_lq;
	logic       act_end_held;
	logic       act_set_skip;
	logic       at_cap;
	logic       has_res;
	logic [6:0] fields_inc;

	result_t    res;
	logic       inside_quote_d;
	logic       has_content_d;
	logic       close_pending_d;
	logic       skip_quote_d;
	logic [5:0] held_spaces_d;
	logic       held_ovf_d;
	logic [6:0] fields_done_d;

	assign at_cap     = (fields_done_q >= cfg.field_cap);
	assign fields_inc = fields_done_q + 7'd1;
	assign pop        = head_valid && (!out_valid_q || !out_stall);

	// step decoder
	always_comb begin
		act          = csvfs_pkg::ACT_IGNORE;
		act_lq       = 1'b0;
		act_end_held = 1'b0;
		act_set_skip = 1'b0;
		if (head_item.eol) begin
			act          = at_cap ? csvfs_pkg::ACT_CAPEOL : csvfs_pkg::ACT_END;
			act_end_held = close_pending_q && !cfg.trim;
		end else if (at_cap) begin
			act = csvfs_pkg::ACT_IGNORE;
		end else if (skip_quote_q && head_item.is_quote) begin
			act = csvfs_pkg::ACT_DROP;
		end else if (close_pending_q) begin
			if (head_item.is_quote) begin
				act = (held_spaces_q == 6'd0 && !held_ovf_q) ? csvfs_pkg::ACT_EMIT
					: csvfs_pkg::ACT_LITQ;
			end else if (head_item.is_space) begin
				act = csvfs_pkg::ACT_HOLD;
			end else if (head_item.is_comma) begin
				act          = csvfs_pkg::ACT_END;
				act_end_held = !cfg.trim;
			end else begin
				act    = csvfs_pkg::ACT_EMIT;
				act_lq = 1'b1;
			end
		end else if (head_item.is_quote) begin
			if (inside_quote_q) begin
				act = csvfs_pkg::ACT_PEND;
			end else if (!has_content_q) begin
				act = csvfs_pkg::ACT_OPEN;
			end else begin
				act          = csvfs_pkg::ACT_EMIT;
				act_set_skip = 1'b1;
			end
		end else if (inside_quote_q) begin
			act = csvfs_pkg::ACT_EMIT;
		end else if (head_item.is_comma) begin
			act = csvfs_pkg::ACT_END;
		end else if (cfg.trim && head_item.is_space) begin
			act = has_content_q ? csvfs_pkg::ACT_HOLD : csvfs_pkg::ACT_DROP;
		end else begin
			act = csvfs_pkg::ACT_EMIT;
		end
	end

	// state update and result
	always_comb begin
		res             = '0;
		has_res         = 1'b0;
		inside_quote_d  = inside_quote_q;
		has_content_d   = has_content_q;
		close_pending_d = close_pending_q;
		skip_quote_d    = 1'b0;
		held_spaces_d   = held_spaces_q;
		held_ovf_d      = held_ovf_q;
		fields_done_d   = fields_done_q;
		unique case (act)
			csvfs_pkg::ACT_IGNORE: begin
				skip_quote_d = skip_quote_q;
			end
			csvfs_pkg::ACT_DROP: ;
			csvfs_pkg::ACT_HOLD: begin
				if (held_spaces_q < csvfs_pkg::SPACE_CAP) begin
					held_spaces_d = held_spaces_q + 6'd1;
				end else begin
					held_ovf_d = 1'b1;
				end
			end
			csvfs_pkg::ACT_OPEN: begin
				inside_quote_d = 1'b1;
			end
			csvfs_pkg::ACT_PEND: begin
				close_pending_d = 1'b1;
				held_spaces_d   = 6'd0;
				held_ovf_d      = 1'b0;
			end
			csvfs_pkg::ACT_EMIT: begin
				has_res            = 1'b1;
				res.lead_quote     = act_lq;
				res.lead_spaces    = held_spaces_q;
				res.char_valid     = 1'b1;
				res.out_char       = head_item.ch;
				res.field_index    = fields_done_q[5:0];
				res.field_count    = fields_done_q;
				res.space_overflow = held_ovf_q;
				held_spaces_d      = 6'd0;
				held_ovf_d         = 1'b0;
				has_content_d      = 1'b1;
				close_pending_d    = 1'b0;
				skip_quote_d       = act_set_skip;
			end
			csvfs_pkg::ACT_LITQ: begin
				has_res            = 1'b1;
				res.lead_quote     = 1'b1;
				res.lead_spaces    = held_spaces_q;
				res.field_index    = fields_done_q[5:0];
				res.field_count    = fields_done_q;
				res.space_overflow = held_ovf_q;
				held_spaces_d      = 6'd0;
				held_ovf_d         = 1'b0;
				has_content_d      = 1'b1;
			end
			csvfs_pkg::ACT_END: begin
				has_res            = 1'b1;
				res.lead_spaces    = act_end_held ? held_spaces_q : 6'd0;
				res.field_end      = 1'b1;
				res.field_index    = fields_done_q[5:0];
				res.line_end       = head_item.eol;
				res.field_count    = fields_inc;
				res.space_overflow = held_ovf_q;
				inside_quote_d     = 1'b0;
				has_content_d      = 1'b0;
				close_pending_d    = 1'b0;
				held_spaces_d      = 6'd0;
				held_ovf_d         = 1'b0;
				fields_done_d      = head_item.eol ? 7'd0 : fields_inc;
			end
			csvfs_pkg::ACT_CAPEOL: begin
				has_res            = 1'b1;
				res.line_end       = 1'b1;
				res.field_count    = fields_done_q;
				res.space_overflow = held_ovf_q;
				inside_quote_d     = 1'b0;
				has_content_d      = 1'b0;
				close_pending_d    = 1'b0;
				held_spaces_d      = 6'd0;
				held_ovf_d         = 1'b0;
				fields_done_d      = 7'd0;
			end
			default: begin
				skip_quote_d = skip_quote_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_quote_q  <= 1'b0;
			has_content_q   <= 1'b0;
			close_pending_q <= 1'b0;
			skip_quote_q    <= 1'b0;
			held_spaces_q   <= 6'd0;
			held_ovf_q      <= 1'b0;
			fields_done_q   <= 7'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				inside_quote_q  <= inside_quote_d;
				has_content_q   <= has_content_d;
				close_pending_q <= close_pending_d;
				skip_quote_q    <= skip_quote_d;
				held_spaces_q   <= held_spaces_d;
				held_ovf_q      <= held_ovf_d;
				fields_done_q   <= fields_done_d;
			end
			if (pop && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign lead_quote     = out_q.lead_quote;
	assign lead_spaces    = out_q.lead_spaces;
	assign char_valid     = out_q.char_valid;
	assign out_char       = out_q.out_char;
	assign field_end      = out_q.field_end;
	assign field_index    = out_q.field_index;
	assign line_end       = out_q.line_end;
	assign field_count    = out_q.field_count;
	assign space_overflow = out_q.space_overflow;

`ifndef ASSERT_OFF
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		held_ovf_q |-> held_spaces_q == csvfs_pkg::SPACE_CAP)
		else $error("held overflow without saturated space count");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.line_end |-> fields_done_q == 7'd0 && !inside_quote_q
		&& !close_pending_q)
		else $error("line state not cleared after line end beat");

	a_field_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.field_end && !out_q.line_end |->
		out_q.field_count == fields_done_q)
		else $error("field count out of step with field state");

	a_fields_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fields_done_q <= csvfs_pkg::FIELD_LIMIT)
		else $error("fields done beyond limit");
`endif

endmodule

/* rtl/csv_field_splitter_top.sv */
// Splits a character stream into comma-separated fields, with optional quoting and
// trimming. Takes one character beat per cycle and answers with zero or one result
// beat; a character passes through the queue entry, then the output register, and
// sustained throughput is one character per cycle while the result side does not
// stall, set by the back-end step that updates the quote and field state. Input stalls
// only when the two-entry queue is full, which happens when the result side stalls.
// Depends on csvfs_pkg, csvfs_front, csvfs_queue, csvfs_back.
module csv_field_splitter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       lead_quote,
	output logic [5:0] lead_spaces,
	output logic       char_valid,
	output logic [7:0] out_char,
	output logic       field_end,
	output logic [5:0] field_index,
	output logic       line_end,
	output logic [6:0] field_count,
	output logic       space_overflow
);

	csvfs_pkg::cfg_t  cfg;
	csvfs_pkg::item_t front_item;
	csvfs_pkg::item_t head_item;
	logic             q_full;
	logic             head_valid;
	logic             pop;

	assign in_stall = q_full;

	csvfs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_char     (in_char),
		.end_of_line (end_of_line),
		.cfg         (cfg),
		.item        (front_item)
	);

	csvfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !q_full),
		.push_item  (front_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	csvfs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.lead_quote     (lead_quote),
		.lead_spaces    (lead_spaces),
		.char_valid     (char_valid),
		.out_char       (out_char),
		.field_end      (field_end),
		.field_index    (field_index),
		.line_end       (line_end),
		.field_count    (field_count),
		.space_overflow (space_overflow)
	);

endmodule

/* bench/tb_csv_field_splitter_top.sv */
// Testbench for csv_field_splitter_top: feeds text lines one character per beat and
// checks every result beat against a built-in model of the splitter.
// Depends on csvfs_pkg and the RTL under rtl; reads no files.
module tb_csv_field_splitter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_CHARS = 65;

	typedef struct packed {
		logic       lead_quote;
		logic [5:0] lead_spaces;
		logic       char_valid;
		logic [7:0] out_char;
		logic       field_end;
		logic [5:0] field_index;
		logic       line_end;
		logic [6:0] field_count;
		logic       space_overflow;
	} split_beat_t;

	class csv_split_board;
		bit [6:0] max_fields;
		bit       trim;
		bit [7:0] quote;
		bit       quote_open, has_content, close_pend, skip_quote, held_ovf;
		bit [5:0] held;
		bit [6:0] done;
		split_beat_t owed_beats[$];
		int unsigned errors, n_checked, n_chars, n_lines;

		function new();
			max_fields = csvfs_pkg::RST_MAX_FIELDS;
			trim = csvfs_pkg::RST_TRIM_ENABLE;
			quote = csvfs_pkg::RST_QUOTE_CHAR;
			clear_field();
			done = 0;
		endfunction

		function void set_reg(bit [1:0] idx, bit [7:0] v);
			case (idx)
				csvfs_pkg::CFG_MAX_FIELDS: max_fields = v[6:0];
				csvfs_pkg::CFG_TRIM_ENABLE: trim = v[0];
				csvfs_pkg::CFG_QUOTE_CHAR: quote = v;
				default: ;
			endcase
		endfunction

		function int unsigned field_cap();
			int unsigned m;
			m = (max_fields != 0) ? max_fields : 1;
			if (m > csvfs_pkg::FIELD_LIMIT) m = csvfs_pkg::FIELD_LIMIT;
			return m;
		endfunction

		function void clear_field();
			quote_open = 0;
			has_content = 0;
			close_pend = 0;
			skip_quote = 0;
			held = 0;
			held_ovf = 0;
		endfunction

		function void hold_space();
			if (held < csvfs_pkg::SPACE_CAP) held++;
			else held_ovf = 1;
		endfunction

		function void owe(bit lq, bit [5:0] ls, bit cv, bit [7:0] ch, bit fe, bit [5:0] fi,
				bit le, bit [6:0] fc, bit ov);
			owed_beats.push_back({lq, ls, cv, ch, fe, fi, le, fc, ov});
		endfunction

		function void emit_char(bit lq, bit [7:0] ch);
			owe(lq, held, 1'b1, ch, 1'b0, done[5:0], 1'b0, done, held_ovf);
			held = 0;
			held_ovf = 0;
			has_content = 1;
		endfunction

		function void end_field(bit [5:0] ls, bit le);
			owe(1'b0, ls, 1'b0, 8'd0, 1'b1, done[5:0], le, done + 7'd1, held_ovf);
			done = done + 7'd1;
			clear_field();
		endfunction

		function void split_char(bit [7:0] c, bit eol);
			bit isq;
			isq = (quote != 8'd0) && (c == quote);
			n_chars++;
			if (eol) begin
				n_lines++;
				if (done >= field_cap()) begin
					owe(1'b0, 6'd0, 1'b0, 8'd0, 1'b0, 6'd0, 1'b1, done, held_ovf);
					clear_field();
				end else begin
					end_field((close_pend && !trim) ? held : 6'd0, 1'b1);
				end
				done = 0;
				return;
			end
			if (done >= field_cap()) return;
			if (skip_quote) begin
				skip_quote = 0;
				if (isq) return;
			end
			if (close_pend) begin
				if (isq) begin
					if (held == 0 && !held_ovf) begin
						close_pend = 0;
						emit_char(1'b0, quote);
						return;
					end
					// earlier quote and its spaces go out literal, this one pends
					owe(1'b1, held, 1'b0, 8'd0, 1'b0, done[5:0], 1'b0, done, held_ovf);
					held = 0;
					held_ovf = 0;
					has_content = 1;
					return;
				end
				if (c == csvfs_pkg::CHAR_SPACE) begin
					hold_space();
					return;
				end
				if (c == csvfs_pkg::CHAR_COMMA) begin
					end_field(trim ? 6'd0 : held, 1'b0);
					return;
				end
				close_pend = 0;
				emit_char(1'b1, c);
				return;
			end
			if (isq) begin
				if (quote_open) begin
					close_pend = 1;
					held = 0;
					held_ovf = 0;
				end else if (!has_content) begin
					quote_open = 1;
				end else begin
					skip_quote = 1;
					emit_char(1'b0, quote);
				end
				return;
			end
			if (quote_open) begin
				emit_char(1'b0, c);
				return;
			end
			if (c == csvfs_pkg::CHAR_COMMA) begin
				end_field(6'd0, 1'b0);
				return;
			end
			if (trim && c == csvfs_pkg::CHAR_SPACE) begin
				if (has_content) hold_space();
				return;
			end
			emit_char(1'b0, c);
		endfunction

		function void cmp(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				if (errors < 40)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_beat(split_beat_t got);
			split_beat_t want;
			n_checked++;
			if (owed_beats.size() == 0) begin
				if (errors < 40)
					$display("%0t: result beat %h with nothing expected, got %h", $time,
						{$bits(split_beat_t){1'b0}}, got);
				errors++;
				return;
			end
			want = owed_beats.pop_front();
			cmp("lead_quote", want.lead_quote, got.lead_quote);
			cmp("lead_spaces", want.lead_spaces, got.lead_spaces);
			cmp("char_valid", want.char_valid, got.char_valid);
			cmp("out_char", want.out_char, got.out_char);
			cmp("field_end", want.field_end, got.field_end);
			cmp("field_index", want.field_index, got.field_index);
			cmp("line_end", want.line_end, got.line_end);
			cmp("field_count", want.field_count, got.field_count);
			cmp("space_overflow", want.space_overflow, got.space_overflow);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = csvfs_pkg::CFG_MAX_FIELDS;
	logic [7:0] cfg_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_char = 8'd0;
	logic       end_of_line = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       lead_quote;
	logic [5:0] lead_spaces;
	logic       char_valid;
	logic [7:0] out_char;
	logic       field_end;
	logic [5:0] field_index;
	logic       line_end;
	logic [6:0] field_count;
	logic       space_overflow;

	split_beat_t seen;
	csv_split_board sb;
	int unsigned in_idle_pct = 38;
	int unsigned out_idle_pct = 38;
	logic hold_off = 1'b0;
	int unsigned n_sent = 0;
	int unsigned quiet = 0;

	csv_field_splitter_top uut (.*);

	assign seen = {lead_quote, lead_spaces, char_valid, out_char, field_end, field_index,
		line_end, field_count, space_overflow};

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(0, 99) < out_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.split_char(in_char, end_of_line);
		if (arst_n && out_valid && !out_stall) sb.match_beat(seen);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: watchdog, no beat moved for %0d cycles, %0d results owed", $time,
				quiet, sb.owed_beats.size());
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_beat(input bit [7:0] c, input bit e);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		end_of_line <= e;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
	endtask

	task automatic write_reg(input bit [1:0] idx, input bit [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic apply_config(input bit [6:0] mf, input bit tr, input bit [7:0] qc);
		write_reg(csvfs_pkg::CFG_MAX_FIELDS, {1'b0, mf});
		write_reg(csvfs_pkg::CFG_TRIM_ENABLE, {7'd0, tr});
		write_reg(csvfs_pkg::CFG_QUOTE_CHAR, qc);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain(input int pause);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_beats.size() != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	function automatic bit [7:0] pick_char(bit [7:0] q);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return csvfs_pkg::CHAR_SPACE;
			1: return csvfs_pkg::CHAR_COMMA;
			2: return 8'($urandom_range(0, 255));
			3: return q;
			default: return 8'($urandom_range(97, 122));
		endcase
	endfunction

	task automatic send_line(input bit full);
		int nf, kind;
		bit brief;
		bit [7:0] q;
		q = (sb.quote != 8'd0) ? sb.quote : 8'd34;
		if ($urandom_range(0, 14) == 0) begin
			repeat ($urandom_range(1, 12)) send_beat(8'($urandom_range(0, 255)), 1'b0);
			send_beat(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		brief = full || ($urandom_range(0, 9) == 0);
		nf = brief ? sb.field_cap() + $urandom_range(0, 2) : $urandom_range(1, 5);
		for (int f = 0; f < nf; f++) begin
			if (f != 0) send_beat(csvfs_pkg::CHAR_COMMA, 1'b0);
			if (brief) begin
				if ($urandom_range(0, 1) == 0) send_beat(8'($urandom_range(97, 122)), 1'b0);
				continue;
			end
			repeat ($urandom_range(0, 2)) send_beat(csvfs_pkg::CHAR_SPACE, 1'b0);
			kind = $urandom_range(0, 19);
			if (kind < 8) begin
				repeat ($urandom_range(1, 4)) send_beat(pick_char(q), 1'b0);
				repeat ($urandom_range(0, 2)) send_beat(csvfs_pkg::CHAR_SPACE, 1'b0);
			end else if (kind < 15) begin
				send_beat(q, 1'b0);
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(0, 4) == 0) begin
						send_beat(q, 1'b0);
						send_beat(q, 1'b0);
					end else begin
						send_beat(pick_char(q), 1'b0);
					end
				end
				if ($urandom_range(0, 11) != 0) send_beat(q, 1'b0);
				repeat ($urandom_range(0, 2)) send_beat(csvfs_pkg::CHAR_SPACE, 1'b0);
				if ($urandom_range(0, 5) == 0) send_beat(pick_char(q), 1'b0);
			end else if (kind < 17) begin
				repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
			end else if (kind == 17) begin
				send_beat(8'($urandom_range(97, 122)), 1'b0);
				repeat ($urandom_range(60, 70)) send_beat(csvfs_pkg::CHAR_SPACE, 1'b0);
				if ($urandom_range(0, 1) == 0) send_beat(8'($urandom_range(97, 122)), 1'b0);
			end else if (kind == 18) begin
				send_beat(q, 1'b0);
				send_beat(8'($urandom_range(97, 122)), 1'b0);
				send_beat(q, 1'b0);
				repeat ($urandom_range(60, 70)) send_beat(csvfs_pkg::CHAR_SPACE, 1'b0);
				if ($urandom_range(0, 1) == 0) send_beat(pick_char(q), 1'b0);
			end
		end
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic run_phase(input bit [6:0] mf, input bit tr, input bit [7:0] qc,
			input bit full);
		int unsigned start;
		apply_config(mf, tr, qc);
		start = n_sent;
		send_line(full);
		while (n_sent - start < PHASE_CHARS) send_line(1'b0);
		drain(4);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty line, quoted part with doubled quote and trailing
		// spaces, doubled quote outside quotes, quote made literal by a letter
		send_beat(8'h00, 1'b1);
		send_text("  \"a\"\"b\"  ,x\"\"\"y");
		send_beat(8'hA5, 1'b1);
		send_text("\"q\" z");
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b1);
		drain(4);

		run_phase(7'd1, 1'b0, 8'd34, 1'b0);
		run_phase(7'd64, 1'b1, 8'd34, 1'b1);
		run_phase(7'd0, 1'b1, csvfs_pkg::CHAR_COMMA, 1'b0);
		run_phase(7'd3, 1'b0, csvfs_pkg::CHAR_SPACE, 1'b0);
		run_phase(7'd127, 1'b0, 8'd0, 1'b0);

		// no idling on either side; the receiver holds off long enough to back up
		// the input
		in_idle_pct = 0;
		out_idle_pct = 0;
		fork
			begin
				repeat (20) @(posedge clk);
				hold_off <= 1'b1;
				repeat (250) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		run_phase(7'd5, 1'b1, 8'd255, 1'b0);
		in_idle_pct = 38;
		out_idle_pct = 38;

		run_phase(7'd16, 1'b0, 8'd34, 1'b0);
		run_phase(7'd2, 1'b1, 8'd34, 1'b0);
		drain(8);

		$display("Sent %0d characters in %0d lines over 9 register settings;", sb.n_chars,
			sb.n_lines);
		$display("checked %0d result beats, %0d mismatches.", sb.n_checked, sb.errors);
		if (sb.errors == 0 && sb.owed_beats.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
